FILE: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("assertion failed");

// same-cycle implication, off while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/rud_pkg.sv
// shared types, constants and helpers of the restoring unsigned divider
// no dependencies
package rud_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned PortWidth = 64;
  localparam int unsigned Bits16    = 16;
  localparam int unsigned Bits32    = 32;
  localparam int unsigned Bits64    = 64;

  typedef enum logic [1:0] {
    Width16 = 2'd0,
    Width32 = 2'd1,
    Width64 = 2'd2
  } width_sel_e;

  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] dq;
    logic [DataWidth-1:0] dvs;
    width_sel_e           wsel;
  } stage_t;

  function automatic logic [DataWidth-1:0] width_mask(width_sel_e sel);
    int unsigned          w;
    logic [DataWidth-1:0] m;
    case (sel)
      Width16: w = Bits16;
      Width32: w = Bits32;
      default: w = Bits64;
    endcase
    if (w > DataWidth) w = DataWidth;
    for (int unsigned i = 0; i < DataWidth; i++) begin
      m[i] = (i < w);
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/rud_stage.sv
// one restoring shift-subtract step with its pipeline register and flow control
// depends on rud_pkg
module rud_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  rud_pkg::stage_t up_data_i,
  output logic            up_ready_o,
  output logic            dn_valid_o,
  output rud_pkg::stage_t dn_data_o,
  input  logic            dn_ready_i
);
  import rud_pkg::*;

  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   diff;
  logic                 qbit;
  stage_t               step;
  logic                 valid_d, valid_q;
  stage_t               data_q;

  always_comb begin
    trial    = {up_data_i.rem, up_data_i.dq[DataWidth-1]};
    diff     = trial - {1'b0, up_data_i.dvs};
    qbit     = ~diff[DataWidth];
    step     = up_data_i;
    step.rem = qbit ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    step.dq  = {up_data_i.dq[DataWidth-2:0], qbit};
  end

  assign up_ready_o = ~valid_q | dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= step;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: hw/rtl/restoring_unsigned_divider_top.sv
// top level of the restoring unsigned divider: chain of single-bit division stages
// depends on rud_pkg and rud_stage
//
// Usage:
//   Request channel: in_valid_i with dividend_i, divisor_i and width_sel_i;
//   the block raises in_stall_o when it cannot take the request. A request is
//   taken at a rising edge with in_valid_i high and in_stall_o low.
//   width_sel_i selects 16, 32 or 64 bit operands (code 3 acts as 64); only
//   the low bits of that width are used, the quotient is zero-extended.
//   A zero divisor gives a quotient of all ones at the selected width.
//   Result channel: out_valid_o with quotient_o, held while out_stall_i is high.
//   Throughput: one request per cycle while out_stall_i is low. There is one
//   pipeline stage per quotient bit, their number set by the 64-bit datapath
//   whatever the selected width.
//   A stalled receiver only stops stages that are full: empty stages further
//   up keep filling, and in_stall_o rises once the whole chain is occupied.
//   Reset empties every stage; no result is pending afterwards.
module restoring_unsigned_divider_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  input  logic [1:0]  width_sel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] quotient_o
);
  import rud_pkg::*;

  stage_t               chain [DataWidth+1];
  logic [DataWidth:0]   valid;
  logic [DataWidth:0]   ready;
  width_sel_e           in_sel;
  logic [DataWidth-1:0] in_mask;

  assign in_sel  = width_sel_e'(width_sel_i);
  assign in_mask = width_mask(in_sel);

  always_comb begin
    chain[0].rem  = '0;
    chain[0].dq   = dividend_i[DataWidth-1:0] & in_mask;
    chain[0].dvs  = divisor_i[DataWidth-1:0] & in_mask;
    chain[0].wsel = in_sel;
  end

  assign valid[0]   = in_valid_i;
  assign in_stall_o = ~ready[0];

  for (genvar k = 0; k < DataWidth; k++) begin : g_stage
    rud_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (valid[k]),
      .up_data_i  (chain[k]),
      .up_ready_o (ready[k]),
      .dn_valid_o (valid[k+1]),
      .dn_data_o  (chain[k+1]),
      .dn_ready_i (ready[k+1])
    );
  end

  assign ready[DataWidth] = ~out_stall_i;
  assign out_valid_o      = valid[DataWidth];
  assign quotient_o       = PortWidth'(chain[DataWidth].dq & width_mask(chain[DataWidth].wsel));

endmodule

FILE: hw/rtl/rud_checker.sv
// port-level checks on the restoring unsigned divider, bound to its top level
// depends on assert_macros.svh and restoring_unsigned_divider_top
`include "assert_macros.svh"

module rud_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [63:0] dividend_i,
  input logic [63:0] divisor_i,
  input logic [1:0]  width_sel_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] quotient_o
);

  logic [63:0] unused_in;
  assign unused_in = dividend_i ^ divisor_i ^ {62'd0, width_sel_i} ^ {63'd0, in_valid_i};

  // nothing pending while reset is held
  `ASSERT_ALWAYS(a_reset_empty, clk_i, rst_ni || !out_valid_o)
  // the request side only stalls behind a full chain and a stalled result
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // a stalled result is kept
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(quotient_o))

endmodule

bind restoring_unsigned_divider_top rud_checker u_rud_checker (.*);

FILE: sim/quotient_checker.sv
// checker for the restoring unsigned divider: watches both channels, predicts each quotient
// and compares it with the one that comes out; depends on rud_pkg only
module quotient_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  input  logic [1:0]  width_sel_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] quotient_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  logic [63:0] expected_quotients[$];

  function automatic logic [63:0] divide_unsigned(logic [63:0] num, logic [63:0] den,
                                                  logic [1:0] sel);
    int unsigned w;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] partial;
    logic [63:0] q;
    logic        carry;
    case (sel)
      rud_pkg::Width16: w = rud_pkg::Bits16;
      rud_pkg::Width32: w = rud_pkg::Bits32;
      default:          w = rud_pkg::Bits64;
    endcase
    if (w > rud_pkg::DataWidth) w = rud_pkg::DataWidth;
    m = (w >= rud_pkg::Bits64) ? '1 : ((64'd1 << w) - 64'd1);
    x = num & m;
    y = den & m;
    partial = '0;
    q = '0;
    for (int b = int'(w) - 1; b >= 0; b--) begin
      // bit shifted out of the top of the partial remainder forces a subtraction
      carry = partial[w-1];
      partial = ((partial << 1) | 64'(x[b])) & m;
      if (carry || partial >= y) begin
        partial = (partial - y) & m;
        q[b] = 1'b1;
      end
    end
    return q & m;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: quotient 0x%016h, predicted 0x%016h", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_quotients.delete();
      mismatch_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_quotients.size() == 0) begin
          report_mismatch("result with no request outstanding", quotient_i, '0);
        end else begin
          if (quotient_i !== expected_quotients[0]) begin
            report_mismatch("wrong quotient", quotient_i, expected_quotients[0]);
          end
          void'(expected_quotients.pop_front());
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_quotients.push_back(divide_unsigned(dividend_i, divisor_i, width_sel_i));
      end
      pending_o = expected_quotients.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// top of the divider testbench: clock, reset, request and stall stimulus, verdict
// depends on rud_pkg, restoring_unsigned_divider_top and quotient_checker
module testbench;

  localparam int unsigned RandomRequests = 1200;
  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned DrainCycles    = 80;
  localparam logic [1:0]  WidthSat       = 2'd3;

  localparam logic [63:0] DirNum [6] = '{
    '1, '1, '0, '1, 64'h8000_0000_8000_8001, 64'd1
  };
  localparam logic [63:0] DirDen [6] = '{
    64'd1, 64'd0, 64'd0, '1, 64'hFFFF_0000_0000_0007, '1
  };

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallHeavy,
    StallLong
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] dividend_i;
  logic [63:0] divisor_i;
  logic [1:0]  width_sel_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] quotient_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_cycles;
  int unsigned sel_count [4];
  int unsigned zero_divisors;

  restoring_unsigned_divider_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .width_sel_i (width_sel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o)
  );

  quotient_checker u_quotient_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .dividend_i       (dividend_i),
    .divisor_i        (divisor_i),
    .width_sel_i      (width_sel_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .quotient_i       (quotient_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // runs at a falling edge, holds the request until it is taken, returns at a falling edge
  task automatic send_request(logic [63:0] num, logic [63:0] den, logic [1:0] sel);
    in_valid_i  <= 1'b1;
    dividend_i  <= num;
    divisor_i   <= den;
    width_sel_i <= sel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sel_count[sel]++;
    if (den == '0) zero_divisors++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(1, 63);
      3: v = v >> $urandom_range(44, 63);
      4: v = v >> $urandom_range(16, 40);
      default: ;
    endcase
    return v;
  endfunction

  initial begin : receiver_stalls
    stall_mode_e mode;
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          StallNone:   out_stall_i <= 1'b0;
          StallRandom: out_stall_i <= ($urandom_range(0, 1) == 0);
          StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 IdleLimit, pending);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    bit          drained;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    dividend_i    = '0;
    divisor_i     = '0;
    width_sel_i   = rud_pkg::Width16;
    idle_cycles   = 0;
    zero_divisors = 0;
    sel_count     = '{default: 0};
    sent          = 0;
    drained       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corner operands at every selector, saturated one included
    for (int s = 0; s <= int'(WidthSat); s++) begin
      for (int k = 0; k < 6; k++) begin
        send_request(DirNum[k], DirDen[k], 2'(s));
      end
    end
    drain_results();

    while (sent < RandomRequests) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_request(random_operand(), random_operand(), 2'($urandom));
        sent++;
      end
      if (!drained && sent >= RandomRequests / 2) begin
        drain_results();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d divisions: %0d at 16 bits, %0d at 32, %0d at 64, %0d saturated",
             checked, sel_count[rud_pkg::Width16], sel_count[rud_pkg::Width32],
             sel_count[rud_pkg::Width64], sel_count[WidthSat]);
    $display("%0d of them by zero, under bursty requests and patterned result stalls",
             zero_divisors);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rud_pkg.sv
hw/rtl/rud_stage.sv
hw/rtl/restoring_unsigned_divider_top.sv
hw/rtl/rud_checker.sv
sim/quotient_checker.sv
sim/testbench.sv
